/* sv/lfoc_pkg.sv */
package lfoc_pkg;

    // Motor percent ceiling and sonar reading width.
    localparam int unsigned PERCENT_MAX = 100;
    localparam int unsigned RANGE_W     = 8;
    localparam int unsigned SPEED_W     = 7;
    localparam int unsigned PHASE_W     = 3;

    // Configuration register indexes.
    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_TURN      = 2'd1;
    localparam logic [1:0] REG_CRUISE    = 2'd2;

    // Configuration reset values.
    localparam logic [RANGE_W-1:0] THRESHOLD_RST = 8'd7;
    localparam logic [SPEED_W-1:0] TURN_RST      = 7'd45;
    localparam logic [SPEED_W-1:0] CRUISE_RST    = 7'd100;

    // Phase codes as seen on the result port.
    localparam logic [PHASE_W-1:0] CODE_IDLE  = 3'd0;
    localparam logic [PHASE_W-1:0] CODE_SPEED = 3'd1;
    localparam logic [PHASE_W-1:0] CODE_IR    = 3'd2;
    localparam logic [PHASE_W-1:0] CODE_SONAR = 3'd3;
    localparam logic [PHASE_W-1:0] CODE_PIVOT = 3'd4;

    // Phase machine, one-hot.
    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_SPEED = 5'b00010,
        PH_IR    = 5'b00100,
        PH_SONAR = 5'b01000,
        PH_PIVOT = 5'b10000
    } t_phase;

    typedef enum logic [1:0] {
        PV_NONE     = 2'd0,
        PV_REQUIRED = 2'd1,
        PV_LEFT     = 2'd2,
        PV_RIGHT    = 2'd3
    } t_pivot;

    typedef enum logic [1:0] {
        VEER_NONE  = 2'd0,
        VEER_LEFT  = 2'd1,
        VEER_RIGHT = 2'd2
    } t_veer;

    // Configuration values seen by the controller.
    typedef struct packed {
        logic [RANGE_W-1:0] threshold;
        logic [SPEED_W-1:0] turn_speed;
        logic [SPEED_W-1:0] cruise_speed;
    } t_cfg;

    // One result request.
    typedef struct packed {
        logic [SPEED_W-1:0] left_speed;
        logic [SPEED_W-1:0] right_speed;
        logic               left_reverse;
        logic               right_reverse;
        logic               drive_updated;
        logic [PHASE_W-1:0] phase_now;
    } t_result;

    function automatic logic [PHASE_W-1:0] phase_code(input t_phase ph);
        logic [PHASE_W-1:0] code;
        unique case (ph)
            PH_IDLE:  code = CODE_IDLE;
            PH_SPEED: code = CODE_SPEED;
            PH_IR:    code = CODE_IR;
            PH_SONAR: code = CODE_SONAR;
            PH_PIVOT: code = CODE_PIVOT;
            default:  code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

/* sv/lfoc_cfg.sv */
module lfoc_cfg
    import lfoc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [RANGE_W-1:0] r_threshold;
    logic [SPEED_W-1:0] r_turn;
    logic [SPEED_W-1:0] r_cruise;
    logic [1:0]         w_index;
    logic               w_write;
    logic [SPEED_W-1:0] w_speed_low;
    logic [SPEED_W-1:0] w_speed_clamped;

    assign pready  = 1'b1;
    assign w_index = paddr[3:2];
    assign w_write = psel && penable && pwrite && pready;

    // Speed writes keep the low seven bits and saturate at full speed.
    assign w_speed_low     = pwdata[SPEED_W-1:0];
    assign w_speed_clamped = (w_speed_low > SPEED_W'(PERCENT_MAX)) ?
                             SPEED_W'(PERCENT_MAX) : w_speed_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_turn      <= TURN_RST;
            r_cruise    <= CRUISE_RST;
        end else if (w_write) begin
            unique case (w_index)
                REG_THRESHOLD: r_threshold <= pwdata[RANGE_W-1:0];
                REG_TURN:      r_turn      <= w_speed_clamped;
                REG_CRUISE:    r_cruise    <= w_speed_clamped;
                default: ;
            endcase
        end
    end

    // Read back.
    always_comb begin
        unique case (w_index)
            REG_THRESHOLD: prdata = {24'd0, r_threshold};
            REG_TURN:      prdata = {25'd0, r_turn};
            REG_CRUISE:    prdata = {25'd0, r_cruise};
            default:       prdata = 32'd0;
        endcase
    end

    assign o_cfg.threshold    = r_threshold;
    assign o_cfg.turn_speed   = r_turn;
    assign o_cfg.cruise_speed = r_cruise;

endmodule

/* sv/lfoc_hist.sv */
module lfoc_hist
    import lfoc_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_write,
    input  logic [RANGE_W-1:0] i_range_first,
    input  logic [RANGE_W-1:0] i_range_second,
    input  logic [RANGE_W-1:0] i_threshold,
    output logic               o_near
);

    localparam int SLOT_W = $clog2(HISTORY_DEPTH);
    localparam int SUM_W  = RANGE_W + $clog2(HISTORY_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);

    logic [RANGE_W-1:0] r_hist [HISTORY_DEPTH];
    logic [SLOT_W-1:0]  r_slot;
    logic               r_full;
    logic [SUM_W-1:0]   r_sum;

    logic [RANGE_W:0]   w_pair_sum;
    logic [RANGE_W-1:0] w_pair;
    logic [RANGE_W-1:0] w_old;
    logic [SUM_W-1:0]   w_sum_next;
    logic               w_full_next;
    logic [SUM_W-1:0]   w_limit;

    // Average of the two readings, truncated.
    assign w_pair_sum = {1'b0, i_range_first} + {1'b0, i_range_second};
    assign w_pair     = w_pair_sum[RANGE_W:1];

    // Running sum: drop the entry being overwritten once the window is full.
    assign w_old       = r_full ? r_hist[r_slot] : '0;
    assign w_sum_next  = r_sum + SUM_W'(w_pair) - SUM_W'(w_old);
    assign w_full_next = r_full || (r_slot == LAST_SLOT);

    // floor(sum / depth) < threshold is the same as sum < threshold * depth.
    assign w_limit = SUM_W'(i_threshold) * SUM_W'(HISTORY_DEPTH);
    assign o_near  = w_full_next && (w_sum_next < w_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_full <= 1'b0;
            r_sum  <= '0;
        end else if (i_write) begin
            r_slot <= (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
            r_full <= w_full_next;
            r_sum  <= w_sum_next;
        end
    end

    // History entries carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_write) begin
            r_hist[r_slot] <= w_pair;
        end
    end

    // Before the first wrap the zero-slot state always has an empty sum.
    a_sum_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_full && r_slot == '0) |-> (r_sum == '0))
        else $error("history sum not empty at start of window");

    // The window fills exactly when the last slot is written.
    a_full_on_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_write && r_slot == LAST_SLOT) |=> (r_full && r_slot == '0))
        else $error("history did not wrap into full state");

endmodule

/* sv/lfoc_core.sv */
module lfoc_core
    import lfoc_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic               i_ir_left_on_tape,
    input  logic               i_ir_right_on_tape,
    input  logic [RANGE_W-1:0] i_range_first,
    input  logic [RANGE_W-1:0] i_range_second,
    input  t_cfg               i_cfg,
    output t_result            o_result
);

    t_phase             r_phase,      n_phase;
    t_pivot             r_pivot,      n_pivot;
    t_veer              r_veer,       n_veer;
    logic               r_obstacle,   n_obstacle;
    logic [SPEED_W-1:0] r_target_l,   n_target_l;
    logic [SPEED_W-1:0] r_target_r,   n_target_r;
    logic [SPEED_W-1:0] r_drive_l,    n_drive_l;
    logic [SPEED_W-1:0] r_drive_r,    n_drive_r;
    logic               r_drive_l_rev, n_drive_l_rev;
    logic               r_drive_r_rev, n_drive_r_rev;
    logic               w_updated;
    logic               w_sonar_write;
    logic               w_near;

    assign w_sonar_write = i_step && (r_phase == PH_SONAR);

    lfoc_hist #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_write        (w_sonar_write),
        .i_range_first  (i_range_first),
        .i_range_second (i_range_second),
        .i_threshold    (i_cfg.threshold),
        .o_near         (w_near)
    );

    // One step of the phase machine per request.
    always_comb begin
        n_phase       = r_phase;
        n_pivot       = r_pivot;
        n_veer        = r_veer;
        n_obstacle    = r_obstacle;
        n_target_l    = r_target_l;
        n_target_r    = r_target_r;
        n_drive_l     = r_drive_l;
        n_drive_r     = r_drive_r;
        n_drive_l_rev = r_drive_l_rev;
        n_drive_r_rev = r_drive_r_rev;
        w_updated     = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                n_phase = PH_SPEED;
            end
            PH_SPEED: begin
                // Apply the latched targets; direction follows the pivot mode.
                n_phase       = PH_IR;
                n_drive_l     = r_target_l;
                n_drive_r     = r_target_r;
                n_drive_l_rev = (r_pivot == PV_LEFT);
                n_drive_r_rev = (r_pivot == PV_RIGHT);
                w_updated     = 1'b1;
            end
            PH_IR: begin
                // Steer back toward the tape; the left sensor wins a tie.
                n_phase = PH_SONAR;
                if (i_ir_left_on_tape) begin
                    n_target_l = '0;
                    n_target_r = i_cfg.turn_speed;
                    n_veer     = VEER_RIGHT;
                end else if (i_ir_right_on_tape) begin
                    n_target_l = i_cfg.turn_speed;
                    n_target_r = '0;
                    n_veer     = VEER_LEFT;
                end
            end
            PH_SONAR: begin
                n_phase    = r_obstacle ? PH_PIVOT : PH_SPEED;
                n_obstacle = w_near;
                if (w_near) begin
                    // Stop and escalate the pivot request.
                    n_target_l = '0;
                    n_target_r = '0;
                    if (r_pivot == PV_NONE) begin
                        n_pivot = PV_REQUIRED;
                    end else if (r_pivot == PV_REQUIRED) begin
                        n_pivot = PV_LEFT;
                    end
                end else if (r_obstacle) begin
                    // Obstacle has cleared, so resume cruising.
                    n_pivot    = PV_NONE;
                    n_target_l = i_cfg.cruise_speed;
                    n_target_r = i_cfg.cruise_speed;
                end
            end
            PH_PIVOT: begin
                // Spin away from the veer side unless the pivot is only requested.
                n_phase = PH_SPEED;
                if (r_pivot != PV_REQUIRED) begin
                    n_target_l = i_cfg.turn_speed;
                    n_target_r = i_cfg.turn_speed;
                    if (r_veer == VEER_LEFT) begin
                        n_pivot = PV_RIGHT;
                    end else if (r_veer == VEER_RIGHT) begin
                        n_pivot = PV_LEFT;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_pivot       <= PV_NONE;
            r_veer        <= VEER_NONE;
            r_obstacle    <= 1'b0;
            r_target_l    <= '0;
            r_target_r    <= '0;
            r_drive_l     <= '0;
            r_drive_r     <= '0;
            r_drive_l_rev <= 1'b0;
            r_drive_r_rev <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_pivot       <= n_pivot;
            r_veer        <= n_veer;
            r_obstacle    <= n_obstacle;
            r_target_l    <= n_target_l;
            r_target_r    <= n_target_r;
            r_drive_l     <= n_drive_l;
            r_drive_r     <= n_drive_r;
            r_drive_l_rev <= n_drive_l_rev;
            r_drive_r_rev <= n_drive_r_rev;
        end
    end

    // The result reflects the state after this step.
    assign o_result.left_speed    = n_drive_l;
    assign o_result.right_speed   = n_drive_r;
    assign o_result.left_reverse  = n_drive_l_rev;
    assign o_result.right_reverse = n_drive_r_rev;
    assign o_result.drive_updated = w_updated;
    assign o_result.phase_now     = phase_code(n_phase);

    // Both motors are never driven in reverse together.
    a_one_reverse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_drive_l_rev && r_drive_r_rev))
        else $error("both motors reversed");

    // An obstacle always leaves some pivot mode in force.
    a_obstacle_pivot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_obstacle |-> (r_pivot != PV_NONE))
        else $error("obstacle seen with no pivot mode");

    // A pivot step is only reached from a sonar step that followed an obstacle.
    a_pivot_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == PH_SONAR && !r_obstacle) |=> (r_phase == PH_SPEED))
        else $error("pivot entered without obstacle");

endmodule

/* sv/line_follow_obstacle_controller.sv */
// Flow: an accepted request waits in the input register and then moves into the result
// register, whose contents are offered on the result channel.
// Throughput: one request per cycle while the result is not stalled; a stalled result holds
// its register, and the input stalls only once a second request waits behind it.
// Reset: synchronous, active low; it clears the phase machine, the drive and the
// history pointer, and loads the configuration defaults. History entries are not cleared.
module line_follow_obstacle_controller
    import lfoc_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input request channel.
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_ir_left_on_tape,
    input  logic               i_ir_right_on_tape,
    input  logic [RANGE_W-1:0] i_range_first,
    input  logic [RANGE_W-1:0] i_range_second,
    // Result request channel.
    output logic               o_valid,
    input  logic               i_stall,
    output logic [SPEED_W-1:0] o_left_speed,
    output logic [SPEED_W-1:0] o_right_speed,
    output logic               o_left_reverse,
    output logic               o_right_reverse,
    output logic               o_drive_updated,
    output logic [PHASE_W-1:0] o_phase_now,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic               r_in_valid;
    logic               r_ir_left;
    logic               r_ir_right;
    logic [RANGE_W-1:0] r_range_first;
    logic [RANGE_W-1:0] r_range_second;
    logic               r_out_valid;
    t_result            r_result;

    logic               w_accept;
    logic               w_out_free;
    logic               w_move;
    t_cfg               w_cfg;
    t_result            w_result;

    lfoc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Handshake between the input register and the result register.
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_move     = r_in_valid && w_out_free;
    assign o_stall    = r_in_valid && !w_out_free;
    assign w_accept   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ir_left      <= i_ir_left_on_tape;
            r_ir_right     <= i_ir_right_on_tape;
            r_range_first  <= i_range_first;
            r_range_second <= i_range_second;
        end
    end

    // The controller state advances as a request moves into the result register.
    lfoc_core #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (w_move),
        .i_ir_left_on_tape  (r_ir_left),
        .i_ir_right_on_tape (r_ir_right),
        .i_range_first      (r_range_first),
        .i_range_second     (r_range_second),
        .i_cfg              (w_cfg),
        .o_result           (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_result <= w_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_left_speed    = r_result.left_speed;
    assign o_right_speed   = r_result.right_speed;
    assign o_left_reverse  = r_result.left_reverse;
    assign o_right_reverse = r_result.right_reverse;
    assign o_drive_updated = r_result.drive_updated;
    assign o_phase_now     = r_result.phase_now;

    // Input is only held off while a request waits behind a stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled without a blocked result");

    // A stalled result is not overwritten by a moving request.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !w_move)
        else $error("pending result overwritten");

endmodule
